// ----- hdl/omr_pkg.sv -----
// Shared types and sizing constants for the omega network router.
package omr_pkg;

  localparam int PORTS     = 8;
  localparam int PAYLOAD_W = 4;
  localparam int STAGES    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int HALF      = PORTS / 2;
  localparam int STG_IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Register indexes on the configuration port (paddr[2]).
  localparam logic REG_HIGH_PORT_WINS = 1'b0;

  localparam logic HPW_RESET = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic [STAGES-1:0]    dest;
    logic [STAGES-1:0]    src;
    logic [PAYLOAD_W-1:0] pay;
  } pkt_t;

  typedef pkt_t [PORTS-1:0] pkt_vec_t;

endpackage

// ----- hdl/omr_switch.sv -----
// 2x2 switch element: steers two packets by one tag bit, priority decides conflicts.
module omr_switch (
  input  logic          high_port_wins,
  input  omr_pkg::pkt_t a0,
  input  omr_pkg::pkt_t a1,
  input  logic          d0,
  input  logic          d1,
  output omr_pkg::pkt_t o0,
  output omr_pkg::pkt_t o1
);
  import omr_pkg::*;

  pkt_t win;
  pkt_t lose;
  logic wd;
  logic ld;

  always_comb begin
    win  = high_port_wins ? a1 : a0;
    lose = high_port_wins ? a0 : a1;
    wd   = high_port_wins ? d1 : d0;
    ld   = high_port_wins ? d0 : d1;
    o0   = '0;
    o1   = '0;
    if (win.valid) begin
      if (wd) o1 = win;
      else    o0 = win;
      // loser survives only if it heads to the other output
      if (lose.valid && (ld != wd)) begin
        if (ld) o1 = lose;
        else    o0 = lose;
      end
    end else if (lose.valid) begin
      if (ld) o1 = lose;
      else    o0 = lose;
    end
  end

endmodule

// ----- hdl/omr_stage.sv -----
// One network stage: perfect shuffle followed by a column of 2x2 switches.
module omr_stage (
  input  logic                            high_port_wins,
  input  logic [omr_pkg::STG_IDX_W-1:0]   steer_idx,
  input  omr_pkg::pkt_vec_t               pkt_i,
  output omr_pkg::pkt_vec_t               pkt_o
);
  import omr_pkg::*;

  pkt_vec_t shuf;

  always_comb begin
    shuf = pkt_i;
    for (int i = 0; i < HALF; i++) begin
      shuf[2*i]   = pkt_i[i];
      shuf[2*i+1] = pkt_i[i+HALF];
    end
  end

  genvar k;
  generate
    for (k = 0; k < HALF; k++) begin : g_sw
      omr_switch u_sw (
        .high_port_wins (high_port_wins),
        .a0             (shuf[2*k]),
        .a1             (shuf[2*k+1]),
        .d0             (shuf[2*k].dest[steer_idx]),
        .d1             (shuf[2*k+1].dest[steer_idx]),
        .o0             (pkt_o[2*k]),
        .o1             (pkt_o[2*k+1])
      );
    end
    if (PORTS % 2 != 0) begin : g_odd
      // unpaired last position passes straight through
      assign pkt_o[PORTS-1] = shuf[PORTS-1];
    end
  endgenerate

endmodule

// ----- hdl/omr_cfg_regs.sv -----
// APB-style configuration register file holding the switch priority select.
module omr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [omr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [omr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [omr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           high_port_wins
);
  import omr_pkg::*;

  logic hpw_r;
  logic hpw_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    hpw_nxt = hpw_r;
    if (wr_en && (paddr[2] == REG_HIGH_PORT_WINS)) hpw_nxt = pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) hpw_r <= HPW_RESET;
    else        hpw_r <= hpw_nxt;
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HIGH_PORT_WINS) prdata[0] = hpw_r;
  end

  assign high_port_wins = hpw_r;

endmodule

// ----- hdl/omega_network_router.sv -----
// Top level of the omega network router: input beat register, stages, result register.
//
// Usage:
//   A packet set (valid mask, destination tags, payloads, one slot per input
//   port) is taken on any rising edge with start high and busy low. busy is
//   held low, so a new set may enter on every cycle: throughput is one set
//   per clock.
//   The set is captured in an input register, routed through all network
//   stages in one combinational pass, and captured in the result register.
//   Through item_r and strobe_r, out_strobe is high for exactly one cycle,
//   carrying out_valid, out_sources, out_payloads and out_grant_mask.
//   Output slots with no packet read zero sources and payloads.
//   The receiver cannot stall: each result beat is shown for a single cycle.
//   The priority select (register 0 on the APB-style port, byte address 0,
//   bit 0) picks which switch input wins a conflict; the user must change
//   it only while no set is in flight, as the block does not enforce this.
//   Synchronous active-low reset empties the pipeline, drops out_strobe and
//   sets the priority select to its reset value (switch input 1 wins).
module omega_network_router (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  logic [omr_pkg::PORTS-1:0]                   in_valid,
  input  logic [omr_pkg::PORTS*omr_pkg::STAGES-1:0]   in_dest_tags,
  input  logic [omr_pkg::PORTS*omr_pkg::PAYLOAD_W-1:0] in_payloads,
  output logic                                        out_strobe,
  output logic [omr_pkg::PORTS-1:0]                   out_valid,
  output logic [omr_pkg::PORTS*omr_pkg::STAGES-1:0]   out_sources,
  output logic [omr_pkg::PORTS*omr_pkg::PAYLOAD_W-1:0] out_payloads,
  output logic [omr_pkg::PORTS-1:0]                   out_grant_mask,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [omr_pkg::CFG_ADDR_W-1:0]              paddr,
  input  logic [omr_pkg::CFG_DATA_W-1:0]              pwdata,
  output logic [omr_pkg::CFG_DATA_W-1:0]              prdata,
  output logic                                        pready
);
  import omr_pkg::*;

  logic high_port_wins;
  logic accept;

  logic                         item_r;
  logic [PORTS-1:0]             vld_r;
  logic [PORTS*STAGES-1:0]      tags_r;
  logic [PORTS*PAYLOAD_W-1:0]   pay_r;

  logic                         strobe_r;
  logic [PORTS-1:0]             ov_r,  ov_nxt;
  logic [PORTS*STAGES-1:0]      os_r,  os_nxt;
  logic [PORTS*PAYLOAD_W-1:0]   op_r,  op_nxt;
  logic [PORTS-1:0]             gm_r,  gm_nxt;

  pkt_vec_t net [STAGES+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  omr_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .high_port_wins (high_port_wins)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) item_r <= 1'b0;
    else        item_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vld_r  <= in_valid;
      tags_r <= in_dest_tags;
      pay_r  <= in_payloads;
    end
  end

  always_comb begin
    for (int i = 0; i < PORTS; i++) begin
      net[0][i].valid = vld_r[i];
      net[0][i].dest  = tags_r[STAGES*i +: STAGES];
      net[0][i].src   = STAGES'(i);
      net[0][i].pay   = pay_r[PAYLOAD_W*i +: PAYLOAD_W];
    end
  end

  genvar s;
  generate
    for (s = 0; s < STAGES; s++) begin : g_stage
      omr_stage u_stage (
        .high_port_wins (high_port_wins),
        .steer_idx      (STG_IDX_W'(STAGES-1-s)),
        .pkt_i          (net[s]),
        .pkt_o          (net[s+1])
      );
    end
  endgenerate

  always_comb begin
    ov_nxt = '0;
    os_nxt = '0;
    op_nxt = '0;
    gm_nxt = '0;
    for (int j = 0; j < PORTS; j++) begin
      if (net[STAGES][j].valid) begin
        ov_nxt[j]                          = 1'b1;
        os_nxt[STAGES*j +: STAGES]         = net[STAGES][j].src;
        op_nxt[PAYLOAD_W*j +: PAYLOAD_W]   = net[STAGES][j].pay;
        gm_nxt[net[STAGES][j].src]         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= item_r;
  end

  always_ff @(posedge clk) begin
    if (item_r) begin
      ov_r <= ov_nxt;
      os_r <= os_nxt;
      op_r <= op_nxt;
      gm_r <= gm_nxt;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_valid      = ov_r;
  assign out_sources    = os_r;
  assign out_payloads   = op_r;
  assign out_grant_mask = gm_r;

  // every accepted beat yields a result beat, through item_r and strobe_r
  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_strobe)
    else $error("result beat missing after accepted set");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(item_r))
    else $error("result beat without a set in flight");

  // one granted source per occupied output
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($countones(out_valid) == $countones(out_grant_mask)))
    else $error("grant mask does not match occupied outputs");

  // only sources that carried a packet can be granted
  a_grant_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_grant_mask & ~$past(vld_r)) == '0))
    else $error("grant to an input without a packet");

endmodule

// ----- sim/omega_network_router_tb.sv -----
// Self-checking testbench for the omega network router: routes directed and random packet sets, checks beats.
module omega_network_router_tb;
  import omr_pkg::*;

  localparam int TAG_W  = PORTS * STAGES;
  localparam int PAY_W  = PORTS * PAYLOAD_W;
  localparam int PHASES = 4;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int MAX_SHOWN = 40;

  typedef struct packed {
    logic [PORTS-1:0] valid;
    logic [TAG_W-1:0] tags;
    logic [PAY_W-1:0] pays;
  } pkt_set_t;

  typedef struct packed {
    logic [PORTS-1:0] valid;
    logic [TAG_W-1:0] sources;
    logic [PAY_W-1:0] pays;
    logic [PORTS-1:0] grants;
  } routed_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [PORTS-1:0]      in_valid = '0;
  logic [TAG_W-1:0]      in_dest_tags = '0;
  logic [PAY_W-1:0]      in_payloads = '0;
  logic                  out_strobe;
  logic [PORTS-1:0]      out_valid;
  logic [TAG_W-1:0]      out_sources;
  logic [PAY_W-1:0]      out_payloads;
  logic [PORTS-1:0]      out_grant_mask;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pkt_set_t pending_sets[$];
  routed_t  routed_q[$];
  logic     prio_hi = HPW_RESET;
  int       errors = 0;
  int       beats_checked = 0;
  int       sets_with_drops = 0;
  int       burst_left = 1;
  int       gap_left = 0;

  omega_network_router i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_valid       (in_valid),
    .in_dest_tags   (in_dest_tags),
    .in_payloads    (in_payloads),
    .out_strobe     (out_strobe),
    .out_valid      (out_valid),
    .out_sources    (out_sources),
    .out_payloads   (out_payloads),
    .out_grant_mask (out_grant_mask),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shuffle then 2x2 switch per stage, steering on tag bits MSB first.
  function automatic routed_t route_set(pkt_set_t set, logic hi_wins);
    pkt_vec_t cur;
    pkt_vec_t mix;
    pkt_t     win;
    pkt_t     lose;
    routed_t  r;
    int       bitpos;
    r = '0;
    for (int i = 0; i < PORTS; i++) begin
      cur[i].valid = set.valid[i];
      cur[i].dest  = set.tags[STAGES*i +: STAGES];
      cur[i].src   = STAGES'(i);
      cur[i].pay   = set.pays[PAYLOAD_W*i +: PAYLOAD_W];
    end
    for (int s = 0; s < STAGES; s++) begin
      bitpos = STAGES - 1 - s;
      mix = cur;
      for (int i = 0; i < HALF; i++) begin
        mix[2*i]   = cur[i];
        mix[2*i+1] = cur[i+HALF];
      end
      cur = mix;  // an unpaired last slot passes straight through
      for (int i = 0; i + 1 < PORTS; i += 2) begin
        win  = hi_wins ? mix[i+1] : mix[i];
        lose = hi_wins ? mix[i] : mix[i+1];
        cur[i]   = '0;
        cur[i+1] = '0;
        if (win.valid)
          cur[i + int'(win.dest[bitpos])] = win;
        if (lose.valid && !(win.valid && win.dest[bitpos] == lose.dest[bitpos]))
          cur[i + int'(lose.dest[bitpos])] = lose;
      end
    end
    for (int j = 0; j < PORTS; j++) begin
      if (cur[j].valid) begin
        r.valid[j] = 1'b1;
        r.sources[STAGES*j +: STAGES] = cur[j].src;
        r.pays[PAYLOAD_W*j +: PAYLOAD_W] = cur[j].pay;
        r.grants[cur[j].src] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [TAG_W-1:0] random_tags();
    logic [TAG_W+31:0] w;
    for (int i = 0; i < TAG_W; i += 32)
      w[i +: 32] = $urandom;
    return w[TAG_W-1:0];
  endfunction

  function automatic logic [PAY_W-1:0] random_pays();
    logic [PAY_W-1:0] p;
    for (int i = 0; i < PAY_W; i += 16)
      p[i +: 16] = 16'($urandom);
    return p;
  endfunction

  function automatic logic [TAG_W-1:0] permutation_tags();
    int               perm[PORTS];
    int               j;
    int               swap;
    logic [TAG_W-1:0] t;
    for (int i = 0; i < PORTS; i++)
      perm[i] = i;
    for (int i = PORTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int i = 0; i < PORTS; i++)
      t[STAGES*i +: STAGES] = STAGES'(perm[i]);
    return t;
  endfunction

  function automatic logic [TAG_W-1:0] mapped_tags(int kind);
    logic [TAG_W-1:0] t;
    logic [STAGES-1:0] d;
    for (int i = 0; i < PORTS; i++) begin
      d = STAGES'(i);
      case (kind)
        0: t[STAGES*i +: STAGES] = d;
        1: t[STAGES*i +: STAGES] = {<<{d}};
        default: t[STAGES*i +: STAGES] = STAGES'(PORTS - 1 - i);
      endcase
    end
    return t;
  endfunction

  task automatic queue_set(logic [PORTS-1:0] v, logic [TAG_W-1:0] t, logic [PAY_W-1:0] p);
    pkt_set_t item;
    item.valid = v;
    item.tags  = t;
    item.pays  = p;
    pending_sets.insert(pending_sets.size(), item);
  endtask

  task automatic queue_directed();
    logic [TAG_W-1:0] t;
    queue_set('0, random_tags(), random_pays());
    queue_set('1, mapped_tags(0), '1);
    queue_set('1, mapped_tags(0), '0);
    queue_set('1, '0, random_pays());
    queue_set('1, '1, random_pays());
    queue_set('1, mapped_tags(1), random_pays());
    queue_set('1, mapped_tags(2), random_pays());
    for (int i = 0; i < PORTS; i++)
      queue_set(PORTS'(1) << i, random_tags(), random_pays());
    // ports 0 and HALF meet at the first switch: same top bit collides, else both pass
    t = '0;
    t[STAGES*HALF +: STAGES] = STAGES'(1);
    queue_set((PORTS'(1) << HALF) | PORTS'(1), t, random_pays());
    t[STAGES*HALF +: STAGES] = STAGES'(PORTS - 1);
    queue_set((PORTS'(1) << HALF) | PORTS'(1), t, random_pays());
    queue_set({(PORTS/2){2'b01}}, random_tags(), random_pays());
    queue_set({(PORTS/2){2'b10}}, random_tags(), random_pays());
  endtask

  task automatic queue_random(int count);
    logic [PORTS-1:0] v;
    logic [TAG_W-1:0] t;
    logic [STAGES-1:0] hot;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_set('1, permutation_tags(), random_pays());
        4: begin
          v = '1;
          v[$urandom_range(0, PORTS - 1)] = 1'b0;
          queue_set(v, permutation_tags(), random_pays());
        end
        5, 6: queue_set(PORTS'($urandom), random_tags(), random_pays());
        7: begin
          v = '0;
          v[$urandom_range(0, PORTS - 1)] = 1'b1;
          v[$urandom_range(0, PORTS - 1)] = 1'b1;
          queue_set(v, random_tags(), random_pays());
        end
        8: begin
          hot = STAGES'($urandom_range(0, PORTS - 1));
          t = random_tags();
          for (int i = 0; i < PORTS; i++)
            t[STAGES*i +: STAGES] = hot;
          queue_set(PORTS'($urandom), t, random_pays());
        end
        default: queue_set(PORTS'($urandom), permutation_tags(), random_pays());
      endcase
    end
  endtask

  task automatic program_priority(logic value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * int'(REG_HIGH_PORT_WINS));
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    prio_hi = value;
  endtask

  // Sampled on the falling edge so the driver's updates are settled.
  task automatic wait_drained();
    do @(negedge clk); while (pending_sets.size() != 0 || start || routed_q.size() != 0);
  endtask

  // Sender: bursts of random length, random gaps in between.
  always @(posedge clk) begin
    pkt_set_t next_set;
    routed_t  predicted;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted = route_set({in_valid, in_dest_tags, in_payloads}, prio_hi);
        if (predicted.grants != in_valid)
          sets_with_drops++;
        routed_q.insert(routed_q.size(), predicted);
      end
      if (start && busy) begin
        // hold the beat until the block takes it
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_sets.size() != 0) begin
        next_set = pending_sets.pop_front();
        start        <= 1'b1;
        in_valid     <= next_set.valid;
        in_dest_tags <= next_set.tags;
        in_payloads  <= next_set.pays;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Receiver: every strobed beat is compared with the oldest prediction.
  always @(posedge clk) begin
    routed_t exp_beat;
    if (rst_n && out_strobe) begin
      if (routed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: result beat with no packet set pending, valid %h", $time, out_valid);
      end else begin
        exp_beat = routed_q.pop_front();
        beats_checked++;
        if (out_valid !== exp_beat.valid) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: out_valid expected %h actual %h", $time, exp_beat.valid, out_valid);
        end
        if (out_sources !== exp_beat.sources) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: out_sources expected %h actual %h",
                     $time, exp_beat.sources, out_sources);
        end
        if (out_payloads !== exp_beat.pays) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: out_payloads expected %h actual %h",
                     $time, exp_beat.pays, out_payloads);
        end
        if (out_grant_mask !== exp_beat.grants) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: out_grant_mask expected %h actual %h",
                     $time, exp_beat.grants, out_grant_mask);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Timed out with %0d packet sets still pending", routed_q.size());
    $display("[omega_network_router] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // priority select runs reset value, then low, high, low
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0)
        program_priority(ph[0] ? 1'b0 : 1'b1);
      if (ph == 0)
        queue_directed();
      queue_random(RANDOM_PER_PHASE);
      wait_drained();
    end
    repeat (6) @(posedge clk);
    $display("Checked %0d routed packet sets across %0d priority settings;", beats_checked,
             PHASES);
    $display("%0d sets lost packets to switch conflicts", sets_with_drops);
    if (errors == 0) begin
      $display("[omega_network_router] OK");
    end else begin
      $display("[omega_network_router] ERROR");
    end
    $finish;
  end

endmodule
